@@ design/esu_pkg.sv @@
// shared types, codes and the reset contents of the translation table
`default_nettype none
package esu_pkg;

	localparam logic FUNC_TEXT   = 1'b0;
	localparam logic FUNC_DEFINE = 1'b1;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CTRL_MASK = 8'h1F;

	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW    = 8;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_OCT   = 3'd2,
		MODE_HEX   = 3'd3,
		MODE_CARET = 3'd4
	} mode_t;

	typedef struct packed {
		logic       func;
		logic [7:0] in_byte;
		logic [7:0] entry_index;
		logic [7:0] entry_value;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} out_t;

	// up to two results produced by one text beat
	typedef struct packed {
		logic [1:0] n;
		out_t       r0;
		out_t       r1;
	} res_t;

	typedef struct packed {
		logic [1:0] level;
		logic [1:0] free;
	} ob_stat_t;

	function automatic logic [7:0] default_char(input logic [7:0] b);
		logic [7:0] v;
		unique case (b)
			8'd10: v = 8'd32;
			8'h45: v = 8'd67;
			8'h51: v = 8'd34;
			8'h61: v = 8'd7;
			8'h62: v = 8'd8;
			8'h64: v = 8'd127;
			8'h65: v = 8'd27;
			8'h66: v = 8'd12;
			8'h6E: v = 8'd10;
			8'h71: v = 8'd39;
			8'h72: v = 8'd13;
			8'h73: v = 8'd32;
			8'h74: v = 8'd9;
			8'h76: v = 8'd11;
			default: v = b;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ design/escape_sequence_unescaper.sv @@
// top level of the escape sequence unescaper
//
// One beat is accepted per cycle while the result buffer has room for its
// results. The byte is registered together with the translation table
// read, which comes from a ram port with registered read data, and the
// parser works out the results of the beat in the next cycle and pushes
// them into the result buffer once it has room. A beat that gives two
// results (a digit run ended by a byte other than a backslash or caret)
// has them offered one after the other, so the input rate then follows
// the output rate through a two-entry result buffer. Define beats write
// the table at acceptance and give no result; entries never written read
// their built-in default through a valid bit per entry that reset clears.
`default_nettype none
module escape_sequence_unescaper
	import esu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	logic       s1_valid_q;
	in_t        item_s1;
	logic       tvalid_s1;
	logic       tbl_valid_q [TBL_DEPTH];
	logic [7:0] ram_rdata;
	logic [7:0] tbl_val;
	logic       in_fire, fire;
	res_t       res;
	ob_stat_t   stat;

	assign in_fire  = in_valid && in_ready;
	assign fire     = s1_valid_q && (res.n <= stat.free);
	assign in_ready = !s1_valid_q || fire;
	assign tbl_val  = tvalid_s1 ? ram_rdata : default_char(item_s1.in_byte);

	esu_ram #(
		.WIDTH(8),
		.DEPTH(TBL_DEPTH)
	) u_tbl (
		.clk    (clk),
		.wr_en  (in_fire && in_data.func == FUNC_DEFINE),
		.wr_addr(in_data.entry_index),
		.wr_data(in_data.entry_value),
		.rd_en  (in_fire),
		.rd_addr(in_data.in_byte),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			for (int i = 0; i < TBL_DEPTH; i++) begin
				tbl_valid_q[i] <= 1'b0;
			end
		end else begin
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
			if (in_fire && in_data.func == FUNC_DEFINE) begin
				tbl_valid_q[in_data.entry_index] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1   <= in_data;
			tvalid_s1 <= tbl_valid_q[in_data.in_byte];
		end
	end

	esu_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (fire),
		.item   (item_s1),
		.tbl_val(tbl_val),
		.res    (res)
	);

	esu_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.res      (res),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.stat     (stat)
	);

	// buffer never holds more than two results
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= 2'd2)
		else $error("result buffer overfilled");

	// a define beat never produces a result
	a_define_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && item_s1.func == FUNC_DEFINE |-> res.n == 2'd0)
		else $error("define beat produced a result");

	// a written entry is marked valid right after its define beat
	a_tbl_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.func == FUNC_DEFINE |=> tbl_valid_q[$past(in_data.entry_index)])
		else $error("table valid bit not set");

	// input is held off only while a beat waits in the parser stage
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> s1_valid_q && !fire)
		else $error("input stalled with empty parser stage");

endmodule
`default_nettype wire

@@ design/esu_ram.sv @@
// generic single write, single read ram with registered read data
`default_nettype none
module esu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ design/esu_parse.sv @@
// escape parser: mode, accumulator and digit count, results for one text beat
`default_nettype none
module esu_parse
	import esu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       upd,
	input  wire in_t        item,
	input  wire logic [7:0] tbl_val,
	output res_t            res
);

	mode_t      mode_q, mode_n;
	logic [7:0] acc_q, acc_n;
	logic [1:0] cnt_q, cnt_n;

	logic [7:0] b;
	logic       id_emit, id_end;
	mode_t      id_mode;
	logic       is_oct, is_hex;
	logic [3:0] hex_val;
	logic [1:0] cnt_inc;
	res_t       r;

	always_comb begin
		b       = item.in_byte;
		id_emit = (b != CH_BSLASH) && (b != CH_CARET);
		id_end  = (b == CH_NUL);
		if (b == CH_BSLASH) begin
			id_mode = MODE_ESC;
		end else if (b == CH_CARET) begin
			id_mode = MODE_CARET;
		end else begin
			id_mode = MODE_IDLE;
		end
		is_oct = (b >= CH_ZERO) && (b <= CH_SEVEN);
		is_hex = 1'b1;
		hex_val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			hex_val = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			hex_val = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			hex_val = 4'(b - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
		cnt_inc = cnt_q + 2'd1;

		mode_n = mode_q;
		acc_n  = acc_q;
		cnt_n  = cnt_q;
		r      = '0;

		if (item.func == FUNC_TEXT) begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_n = MODE_IDLE;
					if (b == CH_NUL) begin
						r.n  = 2'd1;
						r.r0 = '{out_byte: CH_NUL, run_last: 1'b0, string_end: 1'b1};
					end else if (is_oct) begin
						acc_n  = {5'd0, b[2:0]};
						cnt_n  = 2'd1;
						mode_n = MODE_OCT;
					end else if (b == CH_LOW_X || b == CH_UP_X) begin
						acc_n  = 8'd0;
						cnt_n  = 2'd0;
						mode_n = MODE_HEX;
					end else begin
						r.n  = 2'd1;
						r.r0 = '{out_byte: tbl_val, run_last: 1'b0, string_end: 1'b0};
					end
				end
				MODE_OCT: begin
					if (is_oct) begin
						// value wraps modulo 256
						acc_n = {acc_q[4:0], b[2:0]};
						cnt_n = cnt_inc;
						if (cnt_inc == 2'd3 || cnt_inc == 2'd0) begin
							mode_n = MODE_IDLE;
							cnt_n  = 2'd0;
							r.n    = 2'd1;
							r.r0   = '{out_byte: acc_n, run_last: 1'b0, string_end: 1'b0};
						end
					end else begin
						mode_n = id_mode;
						cnt_n  = 2'd0;
						r.r0   = '{out_byte: acc_q, run_last: 1'b0, string_end: 1'b0};
						r.r1   = '{out_byte: b, run_last: 1'b0, string_end: id_end};
						r.n    = id_emit ? 2'd2 : 2'd1;
					end
				end
				MODE_HEX: begin
					if (is_hex) begin
						acc_n = {acc_q[3:0], hex_val};
						cnt_n = cnt_inc;
						if (cnt_inc == 2'd2 || cnt_inc == 2'd3 || cnt_inc == 2'd0) begin
							mode_n = MODE_IDLE;
							cnt_n  = 2'd0;
							r.n    = 2'd1;
							r.r0   = '{out_byte: acc_n, run_last: 1'b0, string_end: 1'b0};
						end
					end else begin
						mode_n = id_mode;
						cnt_n  = 2'd0;
						r.r0   = '{out_byte: acc_q, run_last: 1'b0, string_end: 1'b0};
						r.r1   = '{out_byte: b, run_last: 1'b0, string_end: id_end};
						r.n    = id_emit ? 2'd2 : 2'd1;
					end
				end
				MODE_CARET: begin
					mode_n = MODE_IDLE;
					r.n    = 2'd1;
					r.r0   = '{out_byte: b & CTRL_MASK, run_last: 1'b0, string_end: id_end};
				end
				default: begin
					mode_n = id_mode;
					if (id_emit) begin
						r.n  = 2'd1;
						r.r0 = '{out_byte: b, run_last: 1'b0, string_end: id_end};
					end
				end
			endcase
		end

		if (r.n == 2'd1) begin
			r.r0.run_last = 1'b1;
		end else if (r.n == 2'd2) begin
			r.r1.run_last = 1'b1;
		end
		res = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= 8'd0;
			cnt_q  <= 2'd0;
		end else if (upd && item.func == FUNC_TEXT) begin
			mode_q <= mode_n;
			acc_q  <= acc_n;
			cnt_q  <= cnt_n;
		end
	end

endmodule
`default_nettype wire

@@ design/esu_outbuf.sv @@
// two-entry result buffer between the parser and the output channel
`default_nettype none
module esu_outbuf
	import esu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t res,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data,
	output ob_stat_t  stat
);

	out_t       slot0_q, slot1_q;
	out_t       slot0_n, slot1_n;
	logic [1:0] level_q, level_n;
	logic [1:0] rem, n_eff;
	logic       pop;

	always_comb begin
		pop   = out_valid && out_ready;
		rem   = level_q - {1'b0, pop};
		n_eff = push ? res.n : 2'd0;

		slot0_n = slot0_q;
		slot1_n = slot1_q;
		if (pop) begin
			slot0_n = slot1_q;
		end
		// append after whatever is left once the head result is gone
		if (rem == 2'd0) begin
			if (n_eff != 2'd0) begin
				slot0_n = res.r0;
			end
			if (n_eff == 2'd2) begin
				slot1_n = res.r1;
			end
		end else if (rem == 2'd1 && n_eff != 2'd0) begin
			slot1_n = res.r0;
		end
		level_n = rem + n_eff;

		stat.level = level_q;
		stat.free  = 2'(3'd2 - {1'b0, level_q} + {2'd0, pop});
	end

	assign out_valid = (level_q != 2'd0);
	assign out_data  = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 2'd0;
		end else begin
			level_q <= level_n;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_n;
		slot1_q <= slot1_n;
	end

endmodule
`default_nettype wire
